// File: src/sccb_pkg.sv
// Shared types, command codes and widths for the SCCB bus master.
package sccb_pkg;

    localparam int DATA_BITS   = 8;
    localparam int CMD_W       = 3;
    localparam int PHASE_W     = 3;
    localparam int BIT_CNT_W   = 4;
    localparam int WAIT_W      = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CMD_W-1:0] CMD_IDLE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NOACK = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WAIT = 1'b1;

    localparam logic [WAIT_W-1:0] LONG_WAIT_RESET  = 16'd50;
    localparam logic [WAIT_W-1:0] SHORT_WAIT_RESET = 16'd10;

    typedef struct packed {
        logic [CMD_W-1:0]     op;
        logic [DATA_BITS-1:0] wr_data;
        logic                 sda_in;
    } in_item_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] rd_data;
        logic                 ack_ok;
        logic                 done_res;
        logic                 busy_res;
        logic                 sda_drive;
        logic                 sda_out;
        logic                 scl;
    } result_t;

endpackage

// File: src/sccb_bus_master_core.sv
// Top level of the SCCB bus master: input register, sequencer step and result register.
// A tick waits in the input register, then steps into the result register on m_tdata.
// Throughput: one tick transaction per cycle while m_tready keeps the result slot free; the
// sequencer step is one pass of logic between the input register and the result register.
// Reset: rst_n clears both stages, loads the wait registers with 50 and 10 ticks and
// parks the bus with clock low, data high and driven, no command in progress.
module sccb_bus_master_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // tick stream in
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // op[2:0], wr_data[10:3], sda_in[11]
    // result stream out
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // scl[0], sda_out[1], sda_drive[2],
                                                      // busy_res[3], done_res[4], ack_ok[5],
                                                      // rd_data[13:6]
    // configuration writes: index 0 long wait, index 1 short wait
    input  logic                           cfg_we,
    input  logic [sccb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sccb_pkg::WAIT_W-1:0]    cfg_data
);
    import sccb_pkg::*;

    logic     item_valid;
    in_item_t item;
    result_t  step_result;
    logic     advance;

    logic     out_valid_reg;
    result_t  out_reg;

    // Step the sequencer whenever a tick is waiting and the result slot is free
    // or being emptied this cycle.
    assign advance = item_valid && (!out_valid_reg || m_tready);

    sccb_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sccb_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .result    (step_result)
    );

    // Result register: hold until the downstream transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.rd_data, out_reg.ack_ok, out_reg.done_res,
                       out_reg.busy_res, out_reg.sda_drive, out_reg.sda_out, out_reg.scl};

endmodule

// File: src/sccb_in_reg.sv
// Input register stage: holds one accepted tick until the step logic consumes it.
module sccb_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,
    input  logic              advance,
    output logic              item_valid,
    output sccb_pkg::in_item_t item
);
    import sccb_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tvalid || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= valid_next;
        end
    end

    // payload: op in the low bits, then wr_data, then sda_in
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.op      <= s_tdata[CMD_W-1:0];
            item_reg.wr_data <= s_tdata[CMD_W +: DATA_BITS];
            item_reg.sda_in  <= s_tdata[CMD_W+DATA_BITS];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: src/sccb_step.sv
// Bus sequencer state, wait registers and the per-tick next-state logic.
module sccb_step (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sccb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sccb_pkg::WAIT_W-1:0]    cfg_data,
    input  logic                           advance,
    input  sccb_pkg::in_item_t             item,
    output sccb_pkg::result_t              result
);
    import sccb_pkg::*;

    localparam logic [1:0] WAIT_LONG  = 2'd0;
    localparam logic [1:0] WAIT_SHORT = 2'd1;
    localparam logic [1:0] WAIT_END   = 2'd2;

    logic [WAIT_W-1:0]    long_wait_reg;
    logic [WAIT_W-1:0]    short_wait_reg;
    logic [CMD_W-1:0]     cmd_reg,   cmd_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [BIT_CNT_W-1:0] bit_reg,   bit_next;
    logic [WAIT_W-1:0]    wait_reg,  wait_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic [DATA_BITS-1:0] rd_reg,    rd_next;
    logic                 scl_reg,   scl_next;
    logic                 sda_reg,   sda_next;
    logic                 sden_reg,  sden_next;
    logic                 ack_reg,   ack_next;

    logic                 run;
    logic                 done;
    logic [1:0]           kind;
    logic [PHASE_W-1:0]   p;
    logic [BIT_CNT_W-1:0] bit_inc;
    logic [WAIT_W-1:0]    wsel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_wait_reg  <= LONG_WAIT_RESET;
            short_wait_reg <= SHORT_WAIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LONG_WAIT:  long_wait_reg  <= cfg_data;
                CFG_SHORT_WAIT: short_wait_reg <= cfg_data;
                default:        long_wait_reg  <= long_wait_reg;
            endcase
        end
    end

    always_comb
    begin
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        wait_next  = wait_reg;
        shift_next = shift_reg;
        rd_next    = rd_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        sden_next  = sden_reg;
        ack_next   = ack_reg;
        run        = 1'b0;
        done       = 1'b0;
        kind       = WAIT_END;
        wsel       = long_wait_reg;

        if (cmd_reg == CMD_IDLE)
        begin
            if (item.op >= CMD_START && item.op <= CMD_NOACK)
            begin
                cmd_next   = item.op;
                phase_next = '0;
                bit_next   = '0;
                wait_next  = '0;
                shift_next = (item.op == CMD_WRITE) ? item.wr_data : '0;
                run        = 1'b1;
            end
        end
        else if (wait_reg != '0)
        begin
            wait_next = wait_reg - 1'b1;
        end
        else
        begin
            run = 1'b1;
        end

        p       = phase_next;
        bit_inc = bit_next + 1'b1;

        if (run)
        begin
            phase_next = p + 1'b1;
            unique case (cmd_next)
                CMD_START:
                begin
                    kind = WAIT_LONG;
                    case (p)
                        3'd0:    sda_next = 1'b1;
                        3'd1:    scl_next = 1'b1;
                        3'd2:    sda_next = 1'b0;
                        3'd3:    scl_next = 1'b0;
                        default: kind = WAIT_END;
                    endcase
                end
                CMD_STOP:
                begin
                    kind = WAIT_LONG;
                    case (p)
                        3'd0:    sda_next = 1'b0;
                        3'd1:    scl_next = 1'b1;
                        3'd2:    sda_next = 1'b1;
                        default: kind = WAIT_END;
                    endcase
                end
                CMD_NOACK:
                begin
                    kind = WAIT_LONG;
                    case (p)
                        3'd0:    sda_next = 1'b1;
                        3'd1:    scl_next = 1'b1;
                        3'd2:    scl_next = 1'b0;
                        3'd3:    sda_next = 1'b0;
                        default: kind = WAIT_END;
                    endcase
                end
                CMD_WRITE:
                begin
                    kind = WAIT_LONG;
                    case (p)
                        3'd0: sda_next = shift_next[DATA_BITS-1];
                        3'd1: scl_next = 1'b1;
                        3'd2:
                        begin
                            scl_next   = 1'b0;
                            shift_next = {shift_next[DATA_BITS-2:0], 1'b0};
                            bit_next   = bit_inc;
                            if (bit_inc < BIT_CNT_W'(DATA_BITS))
                            begin
                                phase_next = '0;
                            end
                        end
                        3'd3: kind = WAIT_SHORT;
                        3'd4: sden_next = 1'b0;
                        3'd5:
                        begin
                            scl_next = 1'b1;
                            kind     = WAIT_SHORT;
                        end
                        3'd6:
                        begin
                            // ACK is good when the slave pulls data low
                            ack_next = !item.sda_in;
                            scl_next = 1'b0;
                        end
                        default:
                        begin
                            sden_next = 1'b1;
                            kind      = WAIT_END;
                        end
                    endcase
                end
                CMD_READ:
                begin
                    kind = WAIT_LONG;
                    case (p)
                        3'd0: sden_next = 1'b0;
                        3'd1: kind = WAIT_LONG;
                        3'd2: scl_next = 1'b1;
                        3'd3:
                        begin
                            shift_next = {shift_next[DATA_BITS-2:0], item.sda_in};
                            scl_next   = 1'b0;
                            bit_next   = bit_inc;
                            if (bit_inc < BIT_CNT_W'(DATA_BITS))
                            begin
                                phase_next = 3'd1;
                            end
                        end
                        default:
                        begin
                            sden_next = 1'b1;
                            rd_next   = shift_next;
                            kind      = WAIT_END;
                        end
                    endcase
                end
                default: kind = WAIT_END;
            endcase

            if (kind == WAIT_END)
            begin
                cmd_next   = CMD_IDLE;
                phase_next = '0;
                done       = 1'b1;
            end
            else
            begin
                wsel      = (kind == WAIT_SHORT) ? short_wait_reg : long_wait_reg;
                // a zero wait counts as one tick
                wait_next = (wsel == '0) ? '0 : wsel - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= CMD_IDLE;
            phase_reg <= '0;
            bit_reg   <= '0;
            wait_reg  <= '0;
            shift_reg <= '0;
            rd_reg    <= '0;
            scl_reg   <= 1'b0;
            sda_reg   <= 1'b1;
            sden_reg  <= 1'b1;
            ack_reg   <= 1'b0;
        end
        else if (advance)
        begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            wait_reg  <= wait_next;
            shift_reg <= shift_next;
            rd_reg    <= rd_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            sden_reg  <= sden_next;
            ack_reg   <= ack_next;
        end
    end

    always_comb
    begin
        result.scl       = scl_next;
        result.sda_out   = sda_next;
        result.sda_drive = sden_next;
        result.busy_res  = (cmd_next != CMD_IDLE);
        result.done_res  = done;
        result.ack_ok    = ack_next;
        result.rd_data   = rd_next;
    end

endmodule

// File: tb/sv/sccb_tick_checker.sv
// Checker for the SCCB bus master: predicts the pin state of every tick and compares results.
`timescale 1ns / 100ps
module sccb_tick_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [15:0]                    s_tdata,    // op[2:0], wr_data[10:3], sda_in[11]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [15:0]                    m_tdata,    // scl[0], sda_out[1], sda_drive[2],
                                                       // busy_res[3], done_res[4], ack_ok[5],
                                                       // rd_data[13:6]
    input  logic                           cfg_we,
    input  logic [sccb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sccb_pkg::WAIT_W-1:0]    cfg_data,
    output logic                           bus_busy,
    output int                             results_waiting,
    output int                             error_count
);
    import sccb_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef enum logic [1:0] {HOLD_LONG, HOLD_SHORT, HOLD_END} hold_t;

    logic [WAIT_W-1:0]    long_ticks;
    logic [WAIT_W-1:0]    short_ticks;
    logic [CMD_W-1:0]     bus_cmd;
    logic [PHASE_W-1:0]   bus_phase;
    logic [BIT_CNT_W-1:0] bits_done;
    logic [WAIT_W-1:0]    hold_left;
    logic [DATA_BITS-1:0] shift_reg;
    logic                 scl_q;
    logic                 sda_q;
    logic                 drive_q;
    logic                 ack_q;
    logic [DATA_BITS-1:0] rd_q;

    result_t expected_pins[$];
    int      mismatches   = 0;
    int      waiting      = 0;
    int      result_index = 0;

    assign bus_busy        = (bus_cmd != CMD_IDLE);
    assign results_waiting = waiting;
    assign error_count     = mismatches;

    task automatic report_mismatch(input string what, input logic [DATA_BITS-1:0] got,
                                   input logic [DATA_BITS-1:0] want);
        if (mismatches < PRINT_CAP)
            $display("checker: result %0d %s: got %0h, expected %0h",
                     result_index, what, got, want);
        mismatches++;
    endtask

    function automatic void load_hold(input hold_t kind);
        logic [WAIT_W-1:0] w;
        w = (kind == HOLD_SHORT) ? short_ticks : long_ticks;
        if (w == '0)
            w = 1;
        hold_left = w - 1'b1;
    endfunction

    // One pin action of the running command; advance the phase and return the wait after it.
    function automatic hold_t pin_action(input logic sda_in);
        logic [PHASE_W-1:0] p;
        p = bus_phase;
        bus_phase = p + 1'b1;
        case (bus_cmd)
            CMD_START:
                case (p)
                    3'd0: begin sda_q = 1'b1; return HOLD_LONG; end
                    3'd1: begin scl_q = 1'b1; return HOLD_LONG; end
                    3'd2: begin sda_q = 1'b0; return HOLD_LONG; end
                    3'd3: begin scl_q = 1'b0; return HOLD_LONG; end
                    default: return HOLD_END;
                endcase
            CMD_STOP:
                case (p)
                    3'd0: begin sda_q = 1'b0; return HOLD_LONG; end
                    3'd1: begin scl_q = 1'b1; return HOLD_LONG; end
                    3'd2: begin sda_q = 1'b1; return HOLD_LONG; end
                    default: return HOLD_END;
                endcase
            CMD_NOACK:
                case (p)
                    3'd0: begin sda_q = 1'b1; return HOLD_LONG; end
                    3'd1: begin scl_q = 1'b1; return HOLD_LONG; end
                    3'd2: begin scl_q = 1'b0; return HOLD_LONG; end
                    3'd3: begin sda_q = 1'b0; return HOLD_LONG; end
                    default: return HOLD_END;
                endcase
            CMD_WRITE:
                case (p)
                    3'd0: begin sda_q = shift_reg[DATA_BITS-1]; return HOLD_LONG; end
                    3'd1: begin scl_q = 1'b1; return HOLD_LONG; end
                    3'd2:
                    begin
                        scl_q     = 1'b0;
                        shift_reg = shift_reg << 1;
                        bits_done = bits_done + 1'b1;
                        if (bits_done < DATA_BITS)
                            bus_phase = '0;
                        return HOLD_LONG;
                    end
                    3'd3: return HOLD_SHORT;
                    3'd4: begin drive_q = 1'b0; return HOLD_LONG; end
                    3'd5: begin scl_q = 1'b1; return HOLD_SHORT; end
                    3'd6:
                    begin
                        ack_q = ~sda_in;
                        scl_q = 1'b0;
                        return HOLD_LONG;
                    end
                    default: begin drive_q = 1'b1; return HOLD_END; end
                endcase
            CMD_READ:
                case (p)
                    3'd0: begin drive_q = 1'b0; return HOLD_LONG; end
                    3'd1: return HOLD_LONG;
                    3'd2: begin scl_q = 1'b1; return HOLD_LONG; end
                    3'd3:
                    begin
                        shift_reg = {shift_reg[DATA_BITS-2:0], sda_in};
                        scl_q     = 1'b0;
                        bits_done = bits_done + 1'b1;
                        if (bits_done < DATA_BITS)
                            bus_phase = 3'd1;
                        return HOLD_LONG;
                    end
                    default:
                    begin
                        drive_q = 1'b1;
                        rd_q    = shift_reg;
                        return HOLD_END;
                    end
                endcase
            default: return HOLD_END;
        endcase
    endfunction

    // Advance the bus sequencer by one tick and return the pin state after it.
    function automatic result_t tick_sequencer(input in_item_t tick);
        logic    run;
        hold_t   kind;
        result_t r;
        run        = 1'b0;
        r.done_res = 1'b0;
        if (bus_cmd == CMD_IDLE) begin
            if (tick.op >= CMD_START && tick.op <= CMD_NOACK) begin
                bus_cmd   = tick.op;
                bus_phase = '0;
                bits_done = '0;
                hold_left = '0;
                shift_reg = (tick.op == CMD_WRITE) ? tick.wr_data : '0;
                run       = 1'b1;
            end
        end
        else if (hold_left != '0)
            hold_left = hold_left - 1'b1;
        else
            run = 1'b1;
        if (run) begin
            kind = pin_action(tick.sda_in);
            if (kind == HOLD_END) begin
                bus_cmd    = CMD_IDLE;
                bus_phase  = '0;
                r.done_res = 1'b1;
            end
            else
                load_hold(kind);
        end
        r.scl       = scl_q;
        r.sda_out   = sda_q;
        r.sda_drive = drive_q;
        r.busy_res  = (bus_cmd != CMD_IDLE);
        r.ack_ok    = ack_q;
        r.rd_data   = rd_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : track
        in_item_t tick;
        result_t  seen;
        result_t  want;
        if (!rst_n) begin
            long_ticks  = LONG_WAIT_RESET;
            short_ticks = SHORT_WAIT_RESET;
            bus_cmd     = CMD_IDLE;
            bus_phase   = '0;
            bits_done   = '0;
            hold_left   = '0;
            shift_reg   = '0;
            scl_q       = 1'b0;
            sda_q       = 1'b1;
            drive_q     = 1'b1;
            ack_q       = 1'b0;
            rd_q        = '0;
            expected_pins.delete();
            waiting     = 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_LONG_WAIT)
                    long_ticks = cfg_data;
                else
                    short_ticks = cfg_data;
            end
            if (m_tvalid && m_tready) begin
                seen = m_tdata[13:0];
                if (expected_pins.size() == 0)
                    report_mismatch("unexpected result", seen.rd_data, '0);
                else begin
                    want = expected_pins.pop_front();
                    if (seen.scl !== want.scl)
                        report_mismatch("scl", seen.scl, want.scl);
                    if (seen.sda_out !== want.sda_out)
                        report_mismatch("sda_out", seen.sda_out, want.sda_out);
                    if (seen.sda_drive !== want.sda_drive)
                        report_mismatch("sda_drive", seen.sda_drive, want.sda_drive);
                    if (seen.busy_res !== want.busy_res)
                        report_mismatch("busy_res", seen.busy_res, want.busy_res);
                    if (seen.done_res !== want.done_res)
                        report_mismatch("done_res", seen.done_res, want.done_res);
                    if (seen.ack_ok !== want.ack_ok)
                        report_mismatch("ack_ok", seen.ack_ok, want.ack_ok);
                    if (seen.rd_data !== want.rd_data)
                        report_mismatch("rd_data", seen.rd_data, want.rd_data);
                end
                result_index++;
            end
            if (s_tvalid && s_tready) begin
                tick.op      = s_tdata[2:0];
                tick.wr_data = s_tdata[10:3];
                tick.sda_in  = s_tdata[11];
                expected_pins.push_back(tick_sequencer(tick));
            end
            waiting = expected_pins.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the SCCB bus master: clock, reset, tick stimulus, result back-pressure, verdict.
`timescale 1ns / 100ps
module tb;
    import sccb_pkg::*;

    // Op codes the block must ignore while idle
    localparam logic [CMD_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] OP_SPARE_HI = 3'd7;

    // Longest receiver hold, in cycles; the watchdog limit sits well above it
    localparam int LONG_HOLD   = 300;
    localparam int QUIET_LIMIT = 3000;

    typedef enum {SDA_RANDOM, SDA_HIGH, SDA_LOW} sda_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;    // op[2:0], wr_data[10:3], sda_in[11]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;    // scl[0], sda_out[1], sda_drive[2], busy_res[3],
                                      // done_res[4], ack_ok[5], rd_data[13:6]
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WAIT_W-1:0]    cfg_data;

    logic      bus_busy;
    int        results_waiting;
    int        error_count;
    int        burst_left = 0;
    sda_mode_t sda_mode   = SDA_RANDOM;

    sccb_bus_master_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sccb_tick_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .bus_busy        (bus_busy),
        .results_waiting (results_waiting),
        .error_count     (error_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one tick transaction and hold it until the block takes it.
    // The sender runs in bursts; at the start of each burst it may drop valid for a gap.
    // Called and returning at a falling edge, so the checker state is already settled.
    task automatic send_tick(input logic [CMD_W-1:0] op, input logic [DATA_BITS-1:0] wr);
        int   gap;
        logic sda;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 30);
            // lower valid only when a real gap follows, never in the step it rises again
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        case (sda_mode)
            SDA_HIGH: sda = 1'b1;
            SDA_LOW:  sda = 1'b0;
            default:  sda = 1'($urandom_range(0, 1));
        endcase
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, sda, wr, op};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        burst_left--;
    endtask

    // Issue one command, then tick until the sequencer is idle again.
    // With noisy set, sprinkle commands into the busy window; the block must ignore them.
    task automatic run_command(input logic [CMD_W-1:0] op, input logic [DATA_BITS-1:0] wr,
                               input bit noisy);
        send_tick(op, wr);
        while (bus_busy)
            send_tick((noisy && $urandom_range(0, 7) == 0)
                          ? CMD_W'($urandom_range(CMD_START, CMD_NOACK)) : CMD_IDLE,
                      DATA_BITS'($urandom));
    endtask

    // Finish any running command with empty ticks, drain every outstanding result,
    // then write both wait registers while the block is idle.
    task automatic set_waits(input logic [WAIT_W-1:0] long_ticks,
                             input logic [WAIT_W-1:0] short_ticks);
        while (bus_busy)
            send_tick(CMD_IDLE, '0);
        s_tvalid  <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (results_waiting != 0 || bus_busy);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LONG_WAIT;
        cfg_data  <= long_ticks;
        @(negedge clk);
        cfg_index <= CFG_SHORT_WAIT;
        cfg_data  <= short_ticks;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random traffic: mostly commands started from idle with random content,
    // some stray commands while busy and some spare or empty ops while idle.
    // Idle ticks that carry no command are left out of the count.
    task automatic random_phase(input int ticks);
        int               counted;
        logic [CMD_W-1:0] op;
        counted = 0;
        while (counted < ticks) begin
            if (bus_busy) begin
                op = ($urandom_range(0, 15) == 0)
                         ? CMD_W'($urandom_range(CMD_IDLE, OP_SPARE_HI)) : CMD_IDLE;
                counted++;
            end
            else if ($urandom_range(0, 9) != 0) begin
                op = CMD_W'($urandom_range(CMD_START, CMD_NOACK));
                counted++;
            end
            else begin
                case ($urandom_range(0, 2))
                    0:       op = CMD_IDLE;
                    1:       op = OP_SPARE_LO;
                    default: op = OP_SPARE_HI;
                endcase
            end
            send_tick(op, DATA_BITS'($urandom));
        end
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_LONG_WAIT;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // run one start on the wait values that reset leaves behind
        run_command(CMD_START, '0, 1'b0);

        // directed: shortest waits, every command, both ACK outcomes, all-ones and
        // all-zeros bytes both ways, spare ops while idle, commands while busy
        set_waits(16'd1, 16'd1);
        sda_mode = SDA_HIGH;
        run_command(CMD_START, '0, 1'b0);
        run_command(CMD_WRITE, 8'hFF, 1'b0);
        run_command(CMD_READ, '0, 1'b0);
        sda_mode = SDA_LOW;
        run_command(CMD_WRITE, 8'h00, 1'b0);
        run_command(CMD_READ, '0, 1'b0);
        sda_mode = SDA_RANDOM;
        run_command(OP_SPARE_LO, 8'hFF, 1'b0);
        run_command(OP_SPARE_HI, 8'h00, 1'b0);
        run_command(CMD_IDLE, 8'h5A, 1'b0);
        run_command(CMD_WRITE, 8'hA5, 1'b1);
        run_command(CMD_READ, '0, 1'b1);
        run_command(CMD_NOACK, '0, 1'b1);
        run_command(CMD_STOP, '0, 1'b1);
        set_waits(16'd2, 16'd3);
        run_command(CMD_START, '0, 1'b0);
        run_command(CMD_WRITE, 8'h3C, 1'b0);
        run_command(CMD_NOACK, '0, 1'b0);
        run_command(CMD_STOP, '0, 1'b0);

        // zero in both wait registers counts as a one-tick wait
        set_waits(16'd0, 16'd0);
        run_command(CMD_WRITE, DATA_BITS'($urandom), 1'b0);
        run_command(CMD_STOP, '0, 1'b0);

        // random traffic over several small wait settings
        set_waits(16'd1, 16'd1);
        random_phase(30);
        repeat (4) begin
            set_waits(WAIT_W'($urandom_range(1, 3)), WAIT_W'($urandom_range(1, 2)));
            random_phase(30);
        end

        // drop valid, drain the last results and let the pipeline settle
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (results_waiting != 0);
        repeat (4) @(negedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Result side: alternate free-running stretches with stall patterns, and once
    // (plus now and then) hold off for a long stretch so the block backs up into its input.
    initial begin : receiver
        int stretch;
        int style;
        int rounds;
        m_tready = 1'b0;
        rounds   = 0;
        @(posedge rst_n);
        forever begin
            rounds++;
            if (rounds == 3 || $urandom_range(0, 199) == 0) begin
                repeat (LONG_HOLD) begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
            end
            stretch = $urandom_range(4, 60);
            style   = $urandom_range(0, 2);
            repeat (stretch) begin
                @(negedge clk);
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 2) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side; give up at the limit.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: done, errors");
        $finish;
    end

endmodule
